FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file jse_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/jse_pkg.sv
`default_nettype none
package jse_pkg;

    localparam int CAP_W = 13;
    localparam int LEN_W = 12;

    typedef logic [CAP_W-1:0] cap_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam cap_t CAP_RESET = 13'd4096;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } jse_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       run_last;
        len_t       out_length;
    } jse_result_t;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // job codes passed from front to back
    localparam logic [1:0] JOB_LIT  = 2'd0;
    localparam logic [1:0] JOB_PAIR = 2'd1;
    localparam logic [1:0] JOB_UNI  = 2'd2;
    localparam logic [1:0] JOB_END  = 2'd3;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
        logic       end_ok;
        len_t       length;
    } jse_job_t;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage
`default_nettype wire

FILE: rtl/json_string_escaper.sv
// json string escaper
// input channel: push/full; an item is a data byte or an end-of-string marker.
// result channel: empty/pop; each data byte that fits yields 1, 2 or 6 escaped
// bytes (run_last marks the final one), each end marker yields one ok/fail result
// carrying the escaped length on success.
// configuration: cfg_valid/cfg_ready write channel for out_capacity; cfg_ready
// is always high and writes belong where no item is in flight.
// path: the first result of an item reaches the result ports through the
// job queue write and then the output register; each further byte of an
// escape follows as the receiver takes the one before.
// throughput: one result per cycle while the receiver keeps up; the input takes
// one item per cycle while the four-entry job queue has room, so literal bytes
// stream back to back; a 2- or 6-byte escape occupies the back end until its
// last byte is out, and full rises once the queue holds four jobs.
// reset: queue and output register empty, length and failure flag cleared,
// capacity back to 4096.
// receiver stall: the output register holds, the queue fills, then full
// rises and the input waits; nothing is dropped.
`default_nettype none
module json_string_escaper #(
    parameter int MAX_CAPACITY = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input channel
    input  wire logic                 push,
    output logic                      full,
    input  wire jse_pkg::jse_item_t   item,
    // result channel
    output logic                      empty,
    input  wire logic                 pop,
    output jse_pkg::jse_result_t      result,
    // capacity write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire jse_pkg::cap_t        cfg_data
);

    // front to queue
    logic              q_wr;
    logic              q_full;
    jse_pkg::jse_job_t q_wr_job;

    // queue to back
    logic              q_rd;
    logic              q_empty;
    jse_pkg::jse_job_t q_rd_job;

    // front: classifies bytes, runs the fit test, tracks length and failure
    jse_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_job     (q_wr_job)
    );

    // short job queue decoupling the two halves
    jse_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_job (q_wr_job),
        .full   (q_full),
        .rd     (q_rd),
        .rd_job (q_rd_job),
        .empty  (q_empty)
    );

    // back: expands jobs into output-register results, one per cycle while not stalled
    jse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_rd_job),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

FILE: rtl/jse_queue.sv
`default_nettype none
module jse_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  wire jse_pkg::jse_job_t wr_job,
    output logic                   full,
    input  wire logic              rd,
    output jse_pkg::jse_job_t      rd_job,
    output logic                   empty
);

    jse_pkg::jse_job_t slots_reg [jse_pkg::QUEUE_DEPTH];

    logic [jse_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jse_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jse_pkg::QUEUE_AW:0]   count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign full   = (count_reg == (jse_pkg::QUEUE_AW+1)'(jse_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jse_front.sv
`default_nettype none
module jse_front #(
    parameter int MAX_CAPACITY = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire jse_pkg::jse_item_t item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire jse_pkg::cap_t      cfg_data,
    input  wire logic               q_full,
    output logic                    q_wr,
    output jse_pkg::jse_job_t       q_job
);

    localparam int OFS_W = $clog2(MAX_CAPACITY);
    localparam int SUM_W = ((OFS_W > jse_pkg::CAP_W) ? OFS_W : jse_pkg::CAP_W) + 2;

    logic [OFS_W-1:0] offset_reg, offset_next;
    logic             flag_reg, flag_next;
    jse_pkg::cap_t    cap_reg, cap_next;

    logic             accept;
    logic             is_end;
    logic [1:0]       esc_code;
    logic [7:0]       esc_data;
    logic [2:0]       esc_len;
    logic [SUM_W-1:0] cap_ext;
    logic [SUM_W-1:0] max_ext;
    logic [SUM_W-1:0] eff_cap;
    logic [SUM_W-1:0] need;
    logic             fits;
    logic             end_ok;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;
    assign is_end    = (item.command == jse_pkg::CMD_END);

    // escape class of the incoming byte
    always_comb
    begin
        esc_code = jse_pkg::JOB_LIT;
        esc_data = item.in_byte;
        esc_len  = 3'd1;
        case (item.in_byte)
            jse_pkg::CH_QUOTE:  begin esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; end
            jse_pkg::CH_BSLASH: begin esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; end
            jse_pkg::CH_BS:
            begin
                esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; esc_data = jse_pkg::CH_LOW_B;
            end
            jse_pkg::CH_FF:
            begin
                esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; esc_data = jse_pkg::CH_LOW_F;
            end
            jse_pkg::CH_LF:
            begin
                esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; esc_data = jse_pkg::CH_LOW_N;
            end
            jse_pkg::CH_CR:
            begin
                esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; esc_data = jse_pkg::CH_LOW_R;
            end
            jse_pkg::CH_TAB:
            begin
                esc_code = jse_pkg::JOB_PAIR; esc_len = 3'd2; esc_data = jse_pkg::CH_LOW_T;
            end
            default:
            begin
                if (item.in_byte < jse_pkg::CTRL_LIMIT)
                begin
                    esc_code = jse_pkg::JOB_UNI;
                    esc_len  = 3'd6;
                end
            end
        endcase
    end

    // fit test against the clamped capacity, terminator included
    assign cap_ext = SUM_W'(cap_reg);
    assign max_ext = SUM_W'(MAX_CAPACITY);
    assign eff_cap = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign need    = SUM_W'(offset_reg) + SUM_W'(esc_len) + SUM_W'(1);
    assign fits    = (need <= eff_cap);
    assign end_ok  = !flag_reg && (cap_reg != '0);

    assign q_wr = accept && (is_end || (!flag_reg && fits));

    always_comb
    begin
        q_job.code   = is_end ? jse_pkg::JOB_END : esc_code;
        q_job.data   = esc_data;
        q_job.end_ok = end_ok;
        q_job.length = end_ok ? jse_pkg::len_t'(offset_reg) : '0;
    end

    always_comb
    begin
        offset_next = offset_reg;
        flag_next   = flag_reg;
        cap_next    = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
        if (accept)
        begin
            if (is_end)
            begin
                offset_next = '0;
                flag_next   = 1'b0;
            end
            else if (!flag_reg)
            begin
                if (fits)
                begin
                    offset_next = OFS_W'(SUM_W'(offset_reg) + SUM_W'(esc_len));
                end
                else
                begin
                    flag_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            flag_reg   <= 1'b0;
            cap_reg    <= jse_pkg::CAP_RESET;
        end
        else
        begin
            offset_reg <= offset_next;
            flag_reg   <= flag_next;
            cap_reg    <= cap_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jse_back.sv
`default_nettype none
module jse_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire jse_pkg::jse_job_t q_job,
    output logic                   q_rd,
    output logic                   empty,
    input  wire logic              pop,
    output jse_pkg::jse_result_t   result
);

    logic                 valid_reg, valid_next;
    jse_pkg::jse_result_t result_reg, result_next;
    logic [2:0]           k_reg, k_next;

    logic                 take;
    logic                 load;
    jse_pkg::jse_result_t res;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0, nib};
        if (nib < 4'd10)
        begin
            return jse_pkg::CH_ZERO + wide;
        end
        return jse_pkg::CH_LOW_A + wide - 8'd10;
    endfunction

    assign empty  = !valid_reg;
    assign result = result_reg;
    assign take   = pop && valid_reg;
    assign load   = !q_empty && (!valid_reg || take);
    assign q_rd   = load && res.run_last;

    // result for step k of the head job
    always_comb
    begin
        res.out_kind   = jse_pkg::KIND_BYTE;
        res.out_byte   = q_job.data;
        res.run_last   = 1'b1;
        res.out_length = '0;
        case (q_job.code)
            jse_pkg::JOB_PAIR:
            begin
                res.out_byte = (k_reg == 3'd0) ? jse_pkg::CH_BSLASH : q_job.data;
                res.run_last = (k_reg == 3'd1);
            end
            jse_pkg::JOB_UNI:
            begin
                res.run_last = (k_reg == 3'd5);
                case (k_reg)
                    3'd0:    res.out_byte = jse_pkg::CH_BSLASH;
                    3'd1:    res.out_byte = jse_pkg::CH_LOW_U;
                    3'd4:    res.out_byte = hex_char(q_job.data[7:4]);
                    3'd5:    res.out_byte = hex_char(q_job.data[3:0]);
                    default: res.out_byte = jse_pkg::CH_ZERO;
                endcase
            end
            jse_pkg::JOB_END:
            begin
                res.out_kind   = q_job.end_ok ? jse_pkg::KIND_OK : jse_pkg::KIND_FAIL;
                res.out_byte   = '0;
                res.out_length = q_job.length;
            end
            default:
            begin
                res.out_byte = q_job.data;
            end
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg;
        result_next = result_reg;
        k_next      = k_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            result_next = res;
            k_next      = res.run_last ? 3'd0 : k_reg + 3'd1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

FILE: rtl/jse_checker.sv
`default_nettype none
`include "assert_macros.svh"
module jse_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 empty,
    input wire logic                 pop,
    input wire jse_pkg::jse_result_t result
);

    // end results are single, carry no byte
    `ASSERT_CLK(a_end_single, (!empty && result.out_kind != jse_pkg::KIND_BYTE) |-> (result.run_last && result.out_byte == 8'd0), "end result malformed")

    // only an ok result reports a length
    `ASSERT_CLK(a_len_only_ok, (!empty && result.out_kind != jse_pkg::KIND_OK) |-> (result.out_length == '0), "length on non-ok result")

    // reserved kind code never shows
    `ASSERT_NEVER(a_kind_code, !empty && result.out_kind != jse_pkg::KIND_BYTE && result.out_kind != jse_pkg::KIND_OK && result.out_kind != jse_pkg::KIND_FAIL, "reserved result kind")

    // a waiting result holds until it is taken
    `ASSERT_CLK(a_hold, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")

endmodule

bind json_string_escaper jse_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire
